### hdl/abe_pkg.sv
// shared types and codes for the allocation bitmap engine
package abe_pkg;

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 16;
    localparam int BASE_W   = 4;
    localparam int END_W    = 5;
    localparam int STATUS_W = 3;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_FIND  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK            = 3'd0,
        STAT_ALREADY_SET   = 3'd1,
        STAT_ALREADY_CLEAR = 3'd2,
        STAT_NONE_FREE     = 3'd3,
        STAT_RANGE         = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_ADDR,
        ST_DIV,
        ST_PREP,
        ST_RMW,
        ST_SCAN,
        ST_RESOLVE,
        ST_EMIT
    } state_t;

endpackage

### hdl/allocation_bitmap_engine.sv
// allocation bitmap engine: bitmap store with set, clear, check and find-first-free
//
// Commands arrive on the s_ channel (valid/ready), one result beat per command
// leaves on the m_ channel (valid/ready). One command is in work at a time;
// s_ready is high only while the sequencer is idle.
// Set, clear and check: the block walk steps one block per cycle, then address,
// word divide, read and read-modify-write of one store word.
// Find first free: the scan reads one word per cycle from the single-port store,
// then resolves the bit.
// The word address comes from one shared reciprocal multiplier.
// After reset the store is cleared one word a cycle, all STORE_WORDS words
// (1024 with the default sizes), and no command is taken until that ends.
// A finished result sits in the output register; the next command is taken
// while it waits, and a stalled receiver holds back only the following result.
module allocation_bitmap_engine #(
    parameter int BLOCK_BYTES  = 512,
    parameter int STORE_BLOCKS = 16,
    parameter int WORD_BITS    = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [abe_pkg::CMD_W-1:0]     s_command,
    input  logic [abe_pkg::INDEX_W-1:0]   s_bit_offset,
    input  logic [abe_pkg::BASE_W-1:0]    s_base_block,
    input  logic [abe_pkg::END_W-1:0]     s_end_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [abe_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_bit_value,
    output logic [abe_pkg::INDEX_W-1:0]   m_found_index
);
    import abe_pkg::*;

    localparam int BPW         = WORD_BITS / 8;
    localparam int BPB         = BLOCK_BYTES * 8;
    localparam int STORE_BYTES = STORE_BLOCKS * BLOCK_BYTES;
    localparam int STORE_WORDS = (STORE_BYTES + BPW - 1) / BPW;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int LANE_W      = (BPW > 1) ? $clog2(BPW) : 1;
    localparam int BPOS_W      = $clog2(WORD_BITS);
    localparam int BLK_W       = $clog2(STORE_BLOCKS + 33);
    localparam int BYTE_W      = $clog2((STORE_BLOCKS + 33) * BLOCK_BYTES);
    localparam int SHIFT       = BYTE_W + 3;
    localparam int RECIP       = ((1 << SHIFT) + BPW - 1) / BPW;
    localparam int PROD_W      = BYTE_W + SHIFT + 1;
    localparam int REL_W       = BYTE_W + 3;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    logic [INDEX_W-1:0]     off_reg, off_next;
    logic [BYTE_W-1:0]      k_reg, k_next;
    logic [BYTE_W-1:0]      ke_reg, ke_next;
    logic [AW-1:0]          w_reg, w_next;
    logic [LANE_W-1:0]      lane_reg, lane_next;
    logic [AW-1:0]          wa_reg, wa_next;
    logic [BYTE_W-1:0]      kwa_reg, kwa_next;
    logic [BYTE_W-1:0]      kwd_reg, kwd_next;
    logic                   dval_reg, dval_next;
    logic [7:0]             hit_byte_reg, hit_byte_next;
    logic [BYTE_W-1:0]      rel_byte_reg, rel_byte_next;
    status_t                res_status_reg, res_status_next;
    logic                   res_bit_reg, res_bit_next;
    logic [INDEX_W-1:0]     res_found_reg, res_found_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic                   m_bit_reg, m_bit_next;
    logic [INDEX_W-1:0]     m_found_reg, m_found_next;

    // store and its port
    logic [WORD_BITS-1:0]   mem [STORE_WORDS];
    logic [WORD_BITS-1:0]   rdata_reg;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0]   mem_wdata;

    // datapath helpers
    logic [PROD_W-1:0]      recip_prod;
    logic [BYTE_W-1:0]      kw_calc;
    logic [BPOS_W-1:0]      bit_pos;
    logic                   cur_bit;
    logic [BYTE_W-1:0]      lane_kb;
    logic [7:0]             lane_byte;
    logic [BPW-1:0]         lane_cand;
    logic [LANE_W-1:0]      hit_lane;
    logic [7:0]             sel_byte;
    logic [2:0]             zero_pos;
    logic [REL_W-1:0]       rel_calc;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            dval_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            dval_reg    <= dval_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        blk_reg        <= blk_next;
        off_reg        <= off_next;
        k_reg          <= k_next;
        ke_reg         <= ke_next;
        w_reg          <= w_next;
        lane_reg       <= lane_next;
        wa_reg         <= wa_next;
        kwa_reg        <= kwa_next;
        kwd_reg        <= kwd_next;
        hit_byte_reg   <= hit_byte_next;
        rel_byte_reg   <= rel_byte_next;
        res_status_reg <= res_status_next;
        res_bit_reg    <= res_bit_next;
        res_found_reg  <= res_found_next;
        m_status_reg   <= m_status_next;
        m_bit_reg      <= m_bit_next;
        m_found_reg    <= m_found_next;
    end

    // word address of a byte: multiply by the reciprocal of bytes per word
    assign recip_prod = PROD_W'(k_reg) * PROD_W'(RECIP);
    assign kw_calc    = BYTE_W'(w_reg) * BYTE_W'(BPW);

    // bits are msb first within a byte
    assign bit_pos = BPOS_W'({lane_reg, 3'b111}) - BPOS_W'(off_reg[2:0]);
    assign cur_bit = rdata_reg[bit_pos];

    // first lane of the scanned word that is in range and not full
    always_comb begin
        lane_cand = '0;
        lane_kb   = '0;
        lane_byte = '0;
        for (int l = 0; l < BPW; l++) begin
            lane_kb      = kwd_reg + BYTE_W'(l);
            lane_byte    = rdata_reg[8*l +: 8];
            lane_cand[l] = (lane_kb >= k_reg) && (lane_kb < ke_reg)
                           && (lane_byte != BYTE_FULL);
        end
        hit_lane = '0;
        for (int l = BPW - 1; l >= 0; l--) begin
            if (lane_cand[l]) begin
                hit_lane = LANE_W'(l);
            end
        end
        sel_byte = rdata_reg[{hit_lane, 3'b000} +: 8];
    end

    // first zero bit from the msb of the hit byte
    always_comb begin
        zero_pos = '0;
        for (int q = 7; q >= 0; q--) begin
            if (!hit_byte_reg[3'(7 - q)]) begin
                zero_pos = 3'(q);
            end
        end
        rel_calc = {rel_byte_reg, 3'b000} + REL_W'(zero_pos);
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        off_next        = off_reg;
        k_next          = k_reg;
        ke_next         = ke_reg;
        w_next          = w_reg;
        lane_next       = lane_reg;
        wa_next         = wa_reg;
        kwa_next        = kwa_reg;
        kwd_next        = kwd_reg;
        dval_next       = 1'b0;
        hit_byte_next   = hit_byte_reg;
        rel_byte_next   = rel_byte_reg;
        res_status_next = res_status_reg;
        res_bit_next    = res_bit_reg;
        res_found_next  = res_found_reg;
        clr_next        = clr_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_status_next   = m_status_reg;
        m_bit_next      = m_bit_reg;
        m_found_next    = m_found_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = w_reg;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STORE_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = cmd_t'(s_command);
                    blk_next        = BLK_W'(s_base_block);
                    off_next        = s_bit_offset;
                    ke_next         = BYTE_W'(s_end_block) * BYTE_W'(BLOCK_BYTES);
                    res_status_next = STAT_OK;
                    res_bit_next    = 1'b0;
                    res_found_next  = '0;
                    if (cmd_t'(s_command) != CMD_FIND) begin
                        state_next = ST_WALK;
                    end else begin
                        off_next = '0;
                        if (BLK_W'(s_end_block) > BLK_W'(STORE_BLOCKS)) begin
                            res_status_next = STAT_RANGE;
                            state_next      = ST_EMIT;
                        end else if (BLK_W'(s_end_block) <= BLK_W'(s_base_block)) begin
                            res_status_next = STAT_NONE_FREE;
                            state_next      = ST_EMIT;
                        end else begin
                            state_next = ST_ADDR;
                        end
                    end
                end
            end
            ST_WALK: begin
                // one block per cycle until the offset lies inside the block or the block is out of range
                if (blk_reg >= BLK_W'(STORE_BLOCKS)) begin
                    res_status_next = STAT_RANGE;
                    state_next      = ST_EMIT;
                end else if ({1'b0, off_reg} >= (INDEX_W+1)'(BPB)) begin
                    off_next = off_reg - INDEX_W'(BPB);
                    blk_next = blk_reg + BLK_W'(1);
                end else begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                k_next     = BYTE_W'(blk_reg) * BYTE_W'(BLOCK_BYTES)
                             + BYTE_W'(off_reg >> 3);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                w_next     = recip_prod[SHIFT +: AW];
                state_next = ST_DIV == state_reg ? ST_PREP : ST_DIV;
            end
            ST_PREP: begin
                lane_next = LANE_W'(k_reg - kw_calc);
                wa_next   = w_reg;
                kwa_next  = kw_calc;
                if (cmd_reg == CMD_FIND) begin
                    state_next = ST_SCAN;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = w_reg;
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                mem_waddr = w_reg;
                unique case (cmd_reg)
                    CMD_SET: begin
                        if (cur_bit) begin
                            res_status_next = STAT_ALREADY_SET;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = rdata_reg | (WORD_BITS'(1) << bit_pos);
                        end
                    end
                    CMD_CLEAR: begin
                        if (!cur_bit) begin
                            res_status_next = STAT_ALREADY_CLEAR;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = rdata_reg & ~(WORD_BITS'(1) << bit_pos);
                        end
                    end
                    default: begin
                        res_bit_next = cur_bit;
                    end
                endcase
                state_next = ST_EMIT;
            end
            ST_SCAN: begin
                // read one word ahead, examine the word read last cycle
                if (kwa_reg < ke_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = wa_reg;
                    wa_next   = wa_reg + AW'(1);
                    kwa_next  = kwa_reg + BYTE_W'(BPW);
                    kwd_next  = kwa_reg;
                    dval_next = 1'b1;
                end
                if (dval_reg) begin
                    if (lane_cand != '0) begin
                        hit_byte_next = sel_byte;
                        rel_byte_next = kwd_reg + BYTE_W'(hit_lane) - k_reg;
                        dval_next     = 1'b0;
                        state_next    = ST_RESOLVE;
                    end else if ((kwd_reg + BYTE_W'(BPW)) >= ke_reg) begin
                        res_status_next = STAT_NONE_FREE;
                        dval_next       = 1'b0;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_RESOLVE: begin
                if (rel_calc > REL_W'(INDEX_MAX)) begin
                    res_status_next = STAT_RANGE;
                end else begin
                    res_found_next = rel_calc[INDEX_W-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_bit_next    = res_bit_reg;
                    m_found_next  = res_found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_bit_value   = m_bit_reg;
    assign m_found_index = m_found_reg;

endmodule
